### sv/lmpg_pkg.sv
package lmpg_pkg;

  localparam int BoardWidth = 16;
  localparam int BoardHeight = 16;
  localparam int PresetCount = 14;
  localparam int QueueDepth = 2;
  localparam int QueuePtrWidth = $clog2(QueueDepth);
  localparam int QueueCountWidth = $clog2(QueueDepth + 1);

  localparam logic [3:0] PresetDiagonal = 4'd10;
  localparam logic [3:0] PresetBlocks = 4'd11;
  localparam logic [31:0] IntervalSlow = 32'd1000;
  localparam logic [31:0] IntervalFast = 32'd120;

  localparam logic [0:0] OpTick = 1'b0;
  localparam logic [0:0] OpQuery = 1'b1;

  localparam logic [0:0] RegMoodPreset = 1'b0;

  typedef struct packed {
    logic [0:0] operation;
    logic [31:0] now_ms;
    logic [3:0] pixel_x;
    logic [3:0] pixel_y;
  } in_item_t;

  typedef struct packed {
    logic frame_advanced;
    logic color_valid;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_item_t;

  typedef enum logic [1:0] {
    CmdTick,
    CmdSolid,
    CmdWheel,
    CmdBlank
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e kind;
    logic frame_advanced;
    logic [7:0] arg;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic ready;
  } queue_side_t;

endpackage

### sv/led_mood_pattern_generator_unit.sv
// LED mood-pattern generator. Each item is either a time tick or a pixel color query,
// and each gives exactly one result, in order. The block takes one item per cycle while
// the command queue is not full. The front stage classifies the item in the cycle in which
// it is accepted; the command is then written to the two-entry command queue and from
// there into the result register of the back stage. Ticks update the animation state in
// the front stage, so a query sees every tick accepted before it. The pattern is chosen
// by the mood preset register at address 0; writing it clears the last-update time, and
// values 14 and 15 fold to presets 0 and 1.
module led_mood_pattern_generator_unit
  import lmpg_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push,
  output logic full,
  input  in_item_t in_item_i,
  output logic empty,
  input  logic pop,
  output out_item_t out_item_o,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);

  logic [3:0] preset_q, preset_d;
  logic cfg_write;
  logic preset_write;
  logic accept;
  cmd_t front_cmd;
  cmd_t queue_cmd;
  queue_side_t queue_status;
  logic cmd_pop;

  always_comb begin
    pready = 1'b1;
    cfg_write = psel && penable && pwrite && pready;
    preset_write = cfg_write && (paddr[2:2] == RegMoodPreset);
    preset_d = preset_q;
    if (preset_write) begin
      preset_d = (32'(pwdata[3:0]) >= PresetCount) ?
                 pwdata[3:0] - 4'(PresetCount) : pwdata[3:0];
    end
    prdata = (paddr[2:2] == RegMoodPreset) ? {28'd0, preset_q} : 32'd0;
    full = !queue_status.ready;
    accept = push && !full;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      preset_q <= 4'd0;
    end else begin
      preset_q <= preset_d;
    end
  end

  lmpg_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .item_i      (in_item_i),
    .preset_i    (preset_q),
    .clear_time_i(preset_write),
    .cmd_o       (front_cmd)
  );

  lmpg_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (front_cmd),
    .pop_i   (cmd_pop),
    .data_o  (queue_cmd),
    .status_o(queue_status)
  );

  lmpg_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (queue_cmd),
    .cmd_valid_i(queue_status.valid),
    .cmd_pop_o  (cmd_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_item_o (out_item_o)
  );

  a_preset_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(preset_q) < PresetCount)
    else $error("mood preset outside the defined patterns");

endmodule

### sv/lmpg_front.sv
module lmpg_front
  import lmpg_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic accept_i,
  input  in_item_t item_i,
  input  logic [3:0] preset_i,
  input  logic clear_time_i,
  output cmd_t cmd_o
);

  logic [31:0] last_update_q, last_update_d;
  logic [7:0] anim_offset_q, anim_offset_d;
  logic [31:0] elapsed;
  logic [31:0] interval;
  logic advance;
  logic on_board;
  logic [7:0] diag_pos;
  logic [7:0] block_pos;

  always_comb begin
    interval = (preset_i >= PresetDiagonal) ? IntervalFast : IntervalSlow;
    elapsed = item_i.now_ms - last_update_q;
    advance = (item_i.operation == OpTick) && (elapsed > interval);
    on_board = (9'(item_i.pixel_x) < 9'(BoardWidth)) && (9'(item_i.pixel_y) < 9'(BoardHeight));
    diag_pos = 8'(item_i.pixel_x) * 8'd10 + 8'(item_i.pixel_y) * 8'd10
             + anim_offset_q * 8'd3;
    block_pos = 8'(item_i.pixel_x[3:2]) * 8'd45 + 8'(item_i.pixel_y[3:2]) * 8'd30
              + anim_offset_q * 8'd2;
  end

  always_comb begin
    cmd_o.frame_advanced = 1'b0;
    cmd_o.arg = 8'd0;
    cmd_o.kind = CmdBlank;
    if (item_i.operation == OpTick) begin
      cmd_o.kind = CmdTick;
      cmd_o.frame_advanced = advance;
    end else if (on_board) begin
      if (preset_i < PresetDiagonal) begin
        cmd_o.kind = CmdSolid;
        cmd_o.arg = 8'(preset_i);
      end else if (preset_i == PresetDiagonal) begin
        cmd_o.kind = CmdWheel;
        cmd_o.arg = diag_pos;
      end else if (preset_i == PresetBlocks) begin
        cmd_o.kind = CmdWheel;
        cmd_o.arg = block_pos;
      end
    end
  end

  always_comb begin
    last_update_d = last_update_q;
    anim_offset_d = anim_offset_q;
    if (clear_time_i) begin
      last_update_d = 32'd0;
    end else if (accept_i && advance) begin
      last_update_d = item_i.now_ms;
      anim_offset_d = anim_offset_q + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_update_q <= 32'd0;
      anim_offset_q <= 8'd0;
    end else begin
      last_update_q <= last_update_d;
      anim_offset_q <= anim_offset_d;
    end
  end

  a_advance_stores_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && advance && !clear_time_i) |=> (last_update_q == $past(item_i.now_ms)))
    else $error("last update time not taken from the advancing tick");

  a_offset_steps_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (anim_offset_q != $past(anim_offset_q)) |-> (anim_offset_q == $past(anim_offset_q) + 8'd1))
    else $error("animation offset moved by other than one step");

endmodule

### sv/lmpg_queue.sv
module lmpg_queue
  import lmpg_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t data_i,
  input  logic pop_i,
  output cmd_t data_o,
  output queue_side_t status_o
);

  cmd_t mem_q [QueueDepth];
  logic [QueuePtrWidth-1:0] wr_ptr_q, wr_ptr_d;
  logic [QueuePtrWidth-1:0] rd_ptr_q, rd_ptr_d;
  logic [QueueCountWidth-1:0] count_q, count_d;
  logic do_push, do_pop;

  always_comb begin
    status_o.valid = (count_q != '0);
    status_o.ready = (count_q != QueueCountWidth'(QueueDepth));
    do_push = push_i && status_o.ready;
    do_pop = pop_i && status_o.valid;
    data_o = mem_q[rd_ptr_q];
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d = count_q;
    if (do_push) begin
      wr_ptr_d = (32'(wr_ptr_q) == QueueDepth - 1) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == QueueDepth - 1) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) <= QueueDepth)
    else $error("command queue count beyond its depth");

  a_pointers_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty command queue with pointers apart");

endmodule

### sv/lmpg_back.sv
module lmpg_back
  import lmpg_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  logic cmd_valid_i,
  output logic cmd_pop_o,
  input  logic pop_i,
  output logic empty_o,
  output out_item_t out_item_o
);

  out_item_t out_q, out_d;
  logic out_valid_q, out_valid_d;
  logic [23:0] solid_rgb;
  logic [23:0] wheel_rgb;

  function automatic logic [23:0] solid_color(input logic [3:0] idx);
    logic [23:0] rgb;
    rgb = 24'h000000;
    unique case (idx)
      4'd0: rgb = {8'd255, 8'd255, 8'd255};
      4'd1: rgb = {8'd255, 8'd180, 8'd90};
      4'd2: rgb = {8'd255, 8'd0, 8'd0};
      4'd3: rgb = {8'd255, 8'd80, 8'd0};
      4'd4: rgb = {8'd255, 8'd255, 8'd0};
      4'd5: rgb = {8'd0, 8'd255, 8'd0};
      4'd6: rgb = {8'd0, 8'd255, 8'd255};
      4'd7: rgb = {8'd0, 8'd0, 8'd255};
      4'd8: rgb = {8'd140, 8'd0, 8'd255};
      4'd9: rgb = {8'd255, 8'd0, 8'd120};
      default: rgb = 24'h000000;
    endcase
    return rgb;
  endfunction

  function automatic logic [23:0] color_wheel(input logic [7:0] pos);
    logic [7:0] p;
    logic [7:0] seg;
    logic [7:0] up;
    logic [23:0] rgb;
    p = ~pos;
    if (p < 8'd85) begin
      seg = p;
    end else if (p < 8'd170) begin
      seg = p - 8'd85;
    end else begin
      seg = p - 8'd170;
    end
    up = seg * 8'd3;
    if (p < 8'd85) begin
      rgb = {8'd255 - up, 8'd0, up};
    end else if (p < 8'd170) begin
      rgb = {8'd0, up, 8'd255 - up};
    end else begin
      rgb = {up, 8'd255 - up, 8'd0};
    end
    return rgb;
  endfunction

  always_comb begin
    solid_rgb = solid_color(cmd_i.arg[3:0]);
    wheel_rgb = color_wheel(cmd_i.arg);
    empty_o = !out_valid_q;
    out_item_o = out_q;
    cmd_pop_o = cmd_valid_i && (!out_valid_q || pop_i);

    out_d.frame_advanced = 1'b0;
    out_d.color_valid = 1'b0;
    {out_d.red, out_d.green, out_d.blue} = 24'h000000;
    case (cmd_i.kind)
      CmdTick: begin
        out_d.frame_advanced = cmd_i.frame_advanced;
      end
      CmdSolid: begin
        out_d.color_valid = 1'b1;
        {out_d.red, out_d.green, out_d.blue} = solid_rgb;
      end
      CmdWheel: begin
        out_d.color_valid = 1'b1;
        {out_d.red, out_d.green, out_d.blue} = wheel_rgb;
      end
      default: begin
        out_d.color_valid = 1'b0;
      end
    endcase

    out_valid_d = out_valid_q;
    if (cmd_pop_o) begin
      out_valid_d = 1'b1;
    end else if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  a_result_kinds_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.frame_advanced && out_q.color_valid))
    else $error("result flags both a new frame and a color");

  a_no_color_when_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.color_valid) |->
      ({out_q.red, out_q.green, out_q.blue} == 24'h000000))
    else $error("result carries a color without a valid flag");

endmodule

### tb/tb_top.sv
module tb_top;
  import lmpg_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles = 8;
  localparam int BurstItems = 90;
  localparam logic [2:0] PresetAddr = {RegMoodPreset, 2'b00};
  localparam logic [23:0] SolidRgb [10] = '{
    24'hFFFFFF, 24'hFFB45A, 24'hFF0000, 24'hFF5000, 24'hFFFF00,
    24'h00FF00, 24'h00FFFF, 24'h0000FF, 24'h8C00FF, 24'hFF0078
  };

  typedef enum logic {StepWrite, StepItem} step_kind_e;

  typedef struct {
    step_kind_e kind;
    logic [31:0] wdata;
    in_item_t item;
    logic typed;
    out_item_t want;
  } step_t;

  logic clk_i;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  in_item_t in_item_i = '0;
  logic empty;
  logic pop = 1'b0;
  out_item_t out_item_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  logic typed_on = 1'b0;
  out_item_t typed_led = '0;

  logic [3:0] mood_q = '0;
  logic [31:0] last_ms_q = '0;
  logic [7:0] anim_q = '0;
  out_item_t led_due [$];
  int errors = 0;
  int quiet_cycles = 0;
  int send_idle = 18;
  int recv_idle = 80;

  led_mood_pattern_generator_unit dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push(push),
    .full(full),
    .in_item_i(in_item_i),
    .empty(empty),
    .pop(pop),
    .out_item_o(out_item_o),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic logic [23:0] wheel_rgb(input logic [7:0] pos);
    logic [7:0] p;
    logic [7:0] m;
    p = 8'd255 - pos;
    if (p < 8'd85) begin
      m = 8'(p * 3);
      return {8'd255 - m, 8'd0, m};
    end else if (p < 8'd170) begin
      m = 8'((p - 8'd85) * 3);
      return {8'd0, m, 8'd255 - m};
    end
    m = 8'((p - 8'd170) * 3);
    return {m, 8'd255 - m, 8'd0};
  endfunction

  function automatic out_item_t next_led_result(input in_item_t it);
    out_item_t r;
    logic [31:0] span;
    logic [31:0] elapsed;
    r = '0;
    if (it.operation == OpTick) begin
      span = (mood_q >= PresetDiagonal) ? IntervalFast : IntervalSlow;
      elapsed = it.now_ms - last_ms_q;
      if (elapsed > span) begin
        last_ms_q = it.now_ms;
        anim_q = anim_q + 8'd1;
        r.frame_advanced = 1'b1;
      end
    end else if (int'(it.pixel_x) < BoardWidth && int'(it.pixel_y) < BoardHeight) begin
      if (mood_q < PresetDiagonal) begin
        {r.red, r.green, r.blue} = SolidRgb[mood_q];
      end else if (mood_q == PresetDiagonal) begin
        {r.red, r.green, r.blue} =
            wheel_rgb(8'(it.pixel_x * 10 + it.pixel_y * 10 + anim_q * 3));
      end else if (mood_q == PresetBlocks) begin
        {r.red, r.green, r.blue} =
            wheel_rgb(8'((it.pixel_x / 4) * 45 + (it.pixel_y / 4) * 30 + anim_q * 2));
      end
      r.color_valid = (mood_q <= PresetBlocks);
    end
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk_i) begin : led_checker
    out_item_t due;
    if (!rst_ni) begin
      mood_q = '0;
      last_ms_q = '0;
      anim_q = '0;
    end else begin
      if (pop && !empty) begin
        if (led_due.size() == 0) begin
          $error("result with no item pending: %p", out_item_o);
          errors++;
        end else begin
          due = led_due.pop_front();
          check_field("frame_advanced", 8'(due.frame_advanced),
                      8'(out_item_o.frame_advanced));
          check_field("color_valid", 8'(due.color_valid), 8'(out_item_o.color_valid));
          check_field("red", due.red, out_item_o.red);
          check_field("green", due.green, out_item_o.green);
          check_field("blue", due.blue, out_item_o.blue);
        end
      end
      if (push && !full) begin
        due = next_led_result(in_item_i);
        led_due.push_back(typed_on ? typed_led : due);
      end
      if (psel && penable && pwrite && pready && paddr == PresetAddr) begin
        mood_q = (pwdata[3:0] >= PresetCount) ? pwdata[3:0] - 4'(PresetCount) : pwdata[3:0];
        last_ms_q = '0;
      end
      if ((push && !full) || (pop && !empty) || (psel && penable)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WatchdogLimit) begin
        $display("tb_top: FAIL");
        $finish;
      end
    end
    pop <= rst_ni && ($urandom_range(99) >= recv_idle);
  end

  function automatic out_item_t led(input logic adv, input logic valid,
                                    input logic [23:0] rgb);
    return out_item_t'({adv, valid, rgb});
  endfunction

  function automatic step_t write_step(input logic [31:0] value);
    step_t s;
    s.kind = StepWrite;
    s.wdata = value;
    s.item = '0;
    s.typed = 1'b0;
    s.want = '0;
    return s;
  endfunction

  function automatic step_t item_step(input logic [0:0] op, input logic [31:0] now,
                                      input logic [3:0] x, input logic [3:0] y,
                                      input logic typed, input out_item_t want);
    step_t s;
    s.kind = StepItem;
    s.wdata = '0;
    s.item.operation = op;
    s.item.now_ms = now;
    s.item.pixel_x = x;
    s.item.pixel_y = y;
    s.typed = typed;
    s.want = want;
    return s;
  endfunction

  task automatic offer(input in_item_t it, input logic typed, input out_item_t want);
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    in_item_i <= it;
    typed_on <= typed;
    typed_led <= want;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic settle();
    push <= 1'b0;
    @(posedge clk_i);
    while (led_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_mood(input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PresetAddr;
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin : stimulus
    step_t plan [$];
    in_item_t it;
    logic [31:0] ms;
    logic [31:0] span;
    logic [3:0] mood;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    plan.push_back(item_step(OpQuery, 32'd0, 4'd0, 4'd0, 1'b1, led(1'b0, 1'b1, 24'hFFFFFF)));
    plan.push_back(item_step(OpQuery, 32'hFFFFFFFF, 4'd15, 4'd15, 1'b1,
                             led(1'b0, 1'b1, 24'hFFFFFF)));
    plan.push_back(item_step(OpTick, 32'd1000, 4'd15, 4'd0, 1'b1, led(1'b0, 1'b0, 24'h0)));
    plan.push_back(item_step(OpTick, 32'd1001, 4'd0, 4'd15, 1'b1, led(1'b1, 1'b0, 24'h0)));
    plan.push_back(item_step(OpTick, 32'd0, 4'd0, 4'd0, 1'b1, led(1'b1, 1'b0, 24'h0)));
    plan.push_back(item_step(OpTick, 32'hFFFFFFFF, 4'd15, 4'd15, 1'b1,
                             led(1'b1, 1'b0, 24'h0)));
    plan.push_back(item_step(OpTick, 32'hFFFFFFFF, 4'd5, 4'd10, 1'b1,
                             led(1'b0, 1'b0, 24'h0)));
    plan.push_back(write_step(32'd1));
    plan.push_back(item_step(OpQuery, 32'd0, 4'd3, 4'd4, 1'b1, led(1'b0, 1'b1, 24'hFFB45A)));
    plan.push_back(write_step(32'd15));
    plan.push_back(item_step(OpQuery, 32'd0, 4'd9, 4'd2, 1'b1, led(1'b0, 1'b1, 24'hFFB45A)));
    plan.push_back(write_step(32'd14));
    plan.push_back(item_step(OpQuery, 32'd0, 4'd1, 4'd8, 1'b1, led(1'b0, 1'b1, 24'hFFFFFF)));
    plan.push_back(write_step(32'd9));
    plan.push_back(item_step(OpQuery, 32'd0, 4'd6, 4'd6, 1'b1, led(1'b0, 1'b1, 24'hFF0078)));
    plan.push_back(write_step(32'd3));
    plan.push_back(item_step(OpQuery, 32'd0, 4'd2, 4'd12, 1'b1, led(1'b0, 1'b1, 24'hFF5000)));
    plan.push_back(write_step(32'd8));
    plan.push_back(item_step(OpQuery, 32'd0, 4'd14, 4'd3, 1'b1, led(1'b0, 1'b1, 24'h8C00FF)));
    plan.push_back(write_step(32'd10));
    plan.push_back(item_step(OpTick, 32'd120, 4'd0, 4'd0, 1'b1, led(1'b0, 1'b0, 24'h0)));
    plan.push_back(item_step(OpTick, 32'd121, 4'd0, 4'd0, 1'b1, led(1'b1, 1'b0, 24'h0)));
    plan.push_back(item_step(OpQuery, 32'd0, 4'd0, 4'd0, 1'b0, '0));
    plan.push_back(item_step(OpQuery, 32'd0, 4'd15, 4'd15, 1'b0, '0));
    plan.push_back(write_step(32'd11));
    plan.push_back(item_step(OpQuery, 32'd0, 4'd15, 4'd0, 1'b0, '0));
    plan.push_back(item_step(OpQuery, 32'd0, 4'd0, 4'd15, 1'b0, '0));
    plan.push_back(item_step(OpQuery, 32'd0, 4'd7, 4'd9, 1'b0, '0));
    plan.push_back(write_step(32'd12));
    plan.push_back(item_step(OpQuery, 32'd0, 4'd5, 4'd5, 1'b1, led(1'b0, 1'b0, 24'h0)));
    plan.push_back(item_step(OpTick, 32'd121, 4'd5, 4'd5, 1'b1, led(1'b1, 1'b0, 24'h0)));
    plan.push_back(write_step(32'd13));
    plan.push_back(item_step(OpQuery, 32'd0, 4'd11, 4'd13, 1'b1, led(1'b0, 1'b0, 24'h0)));
    plan.push_back(item_step(OpTick, 32'd0, 4'd11, 4'd13, 1'b1, led(1'b0, 1'b0, 24'h0)));

    foreach (plan[i]) begin
      if (plan[i].kind == StepWrite) begin
        settle();
        write_mood(plan[i].wdata);
      end else begin
        offer(plan[i].item, plan[i].typed, plan[i].want);
      end
    end

    for (int mode = 0; mode < 3; mode++) begin
      for (int burst = 0; burst < 6; burst++) begin
        settle();
        send_idle = (mode == 0) ? 18 : (mode == 1) ? 80 : 0;
        recv_idle = (mode == 0) ? 80 : (mode == 1) ? 18 : 0;
        mood = 4'((mode * 6 + burst) % 16);
        span = (mood >= PresetDiagonal && mood < 4'(PresetCount)) ? IntervalFast
                                                                    : IntervalSlow;
        write_mood({28'($urandom()), mood});
        ms = $urandom_range(1) ? 32'd0 : $urandom();
        repeat (BurstItems) begin
          it.operation = ($urandom_range(99) < 40) ? OpTick : OpQuery;
          it.pixel_x = 4'($urandom());
          it.pixel_y = 4'($urandom());
          it.now_ms = $urandom();
          if (it.operation == OpTick) begin
            case ($urandom_range(15))
              0: ms = $urandom();
              1: ms = ms + span;
              2: ms = ms + span + 32'd1;
              default: ms = ms + $urandom_range(0, 2 * span);
            endcase
            it.now_ms = ms;
          end
          offer(it, 1'b0, '0);
        end
      end
    end

    settle();
    if (errors == 0 && led_due.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

### led_mood_pattern_generator_unit.f
sv/lmpg_pkg.sv
sv/lmpg_front.sv
sv/lmpg_queue.sv
sv/lmpg_back.sv
sv/led_mood_pattern_generator_unit.sv
tb/tb_top.sv
